>>> src/ssnd_pkg.sv
// Shared types, constants and the digit-to-segment table for the
// seven-segment number display. No dependencies.
`default_nettype none

package ssnd_pkg;

    localparam int MAX_DIGITS_DEF = 4;

    // Payload widths
    localparam int CMD_W   = 2;
    localparam int VALUE_W = 16;
    localparam int POS_W   = 2;
    localparam int SEG_W   = 8;
    localparam int DIG_W   = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_USED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS = 2'd2;

    localparam logic [2:0] DIGITS_USED_RST = 3'd4;
    localparam logic [3:0] BLINK_MASK_RST  = 4'd0;
    localparam logic [7:0] DWELL_TICKS_RST = 8'd4;

    // Digit counters are four bits wide and hold positions 0 to 15
    localparam int CNT_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam logic [SEG_W-1:0] SEG_ZERO  = 8'b0011_1111;
    localparam logic [SEG_W-1:0] SEG_MINUS = 8'b0100_0000;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'b0000_0000;
    localparam logic [SEG_W-1:0] SEG_DOT   = 8'b1000_0000;

    // Millisecond phase
    localparam int PHASE_W = 10;
    localparam logic [PHASE_W-1:0] PHASE_LAST     = 10'd999;
    localparam logic [PHASE_W-1:0] BLINK_ON_END   = 10'd200;
    localparam logic [PHASE_W-1:0] OVF_HALF       = 10'd500;
    localparam logic [PHASE_W-1:0] OVF_ON_START   = 10'd300;
    localparam logic [PHASE_W-1:0] OVF_ON_START_2 = 10'd800;

    // q = (m * RECIP_10) >> RECIP_SH is m / 10 for every m below 43691
    localparam logic [15:0] RECIP_10 = 16'd52429;
    localparam int          RECIP_SH = 19;
    localparam logic [3:0]  RADIX    = 4'd10;

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = SEG_ZERO;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> src/ssnd_in_if.sv
// Input channel of the seven-segment number display: valid/ready plus
// command, value and position. Depends on ssnd_pkg.
`default_nettype none

interface ssnd_in_if;
    logic                               valid;
    logic                               ready;
    logic [ssnd_pkg::CMD_W-1:0]         command;
    logic signed [ssnd_pkg::VALUE_W-1:0] value;
    logic [ssnd_pkg::POS_W-1:0]         position;

    modport source (output valid, command, value, position, input ready);
    modport sink   (input valid, command, value, position, output ready);
endinterface

`default_nettype wire

>>> src/ssnd_out_if.sv
// Result channel of the seven-segment number display: valid/ready plus
// segments, digit and overflow. Depends on ssnd_pkg.
`default_nettype none

interface ssnd_out_if;
    logic                       valid;
    logic                       ready;
    logic [ssnd_pkg::SEG_W-1:0] segments;
    logic [ssnd_pkg::DIG_W-1:0] digit;
    logic                       overflow;

    modport source (output valid, segments, digit, overflow, input ready);
    modport sink   (input valid, segments, digit, overflow, output ready);
endinterface

`default_nettype wire

>>> src/seven_segment_number_display.sv
// Multiplexed seven-segment number display controller, top level.
// Depends on ssnd_pkg, ssnd_in_if and ssnd_out_if.
//
// Every transfer on i_in (write, clear, tick or no-op) gives one transfer on
// o_out showing the scanned digit after the update. Clear, tick and no-op go
// from the accept to ST_EMIT, which loads the result register once o_out is
// free. A write runs ST_CONV for each decimal digit of |value| (1..5), then
// ST_SIGN for a negative value, then ST_EMIT; the divide-by-ten unit peels
// off one digit per cycle. i_in.ready is high whenever the sequencer is idle,
// also while the previous result still waits on o_out.
`default_nettype none

module seven_segment_number_display #(
    parameter int MAX_DIGITS = ssnd_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ssnd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ssnd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ssnd_in_if.sink                         i_in,
    ssnd_out_if.source                      o_out
);

    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int NW = ssnd_pkg::CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SIGN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [2:0] r_digits_used, n_digits_used;
    logic [3:0] r_blink, n_blink;
    logic [7:0] r_dwell, n_dwell;

    logic [ssnd_pkg::SEG_W-1:0] r_pat [MAX_DIGITS];
    logic [ssnd_pkg::SEG_W-1:0] n_pat [MAX_DIGITS];
    logic [ssnd_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [7:0] r_cnt, n_cnt;
    logic [1:0] r_scan, n_scan;
    logic       r_ovf, n_ovf;

    // conversion working registers
    logic [15:0]   r_mag, n_mag;
    logic          r_neg, n_neg;
    logic [NW-1:0] r_j, n_j;

    logic                        r_out_valid, n_out_valid;
    logic [ssnd_pkg::SEG_W-1:0]  r_out_seg, n_out_seg;
    logic [ssnd_pkg::DIG_W-1:0]  r_out_dig, n_out_dig;
    logic                        r_out_ovf, n_out_ovf;

    logic [NW-1:0] fitted;
    logic [7:0]    dwell_eff;
    logic [7:0]    cnt_inc;
    logic [2:0]    scan_inc;
    logic          in_xfer;
    logic          out_free;
    logic [15:0]   in_raw;
    logic [31:0]   prod;
    logic [15:0]   quot;
    logic [15:0]   rem_full;
    logic [3:0]    rem;
    logic [ssnd_pkg::SEG_W-1:0] show_seg;
    logic          blink_on;
    logic          ovf_on;

    always_comb begin
        if (r_digits_used == 3'd0) begin
            fitted = NW'(1);
        end else if (int'(r_digits_used) > MAX_DIGITS) begin
            fitted = NW'(MAX_DIGITS);
        end else begin
            fitted = NW'(r_digits_used);
        end
    end

    assign dwell_eff = (r_dwell == 8'd0) ? 8'd1 : r_dwell;
    assign cnt_inc   = r_cnt + 8'd1;
    assign scan_inc  = {1'b0, r_scan} + 3'd1;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign in_raw     = i_in.value;

    // divide-by-ten unit: one decimal digit per cycle
    assign prod     = r_mag * ssnd_pkg::RECIP_10;
    assign quot     = 16'(prod >> ssnd_pkg::RECIP_SH);
    assign rem_full = r_mag - quot * 16'(ssnd_pkg::RADIX);
    assign rem      = rem_full[3:0];

    // displayed digit with its decimal point
    always_comb begin
        if (int'(r_scan) < MAX_DIGITS) begin
            show_seg = r_pat[AW'(r_scan)];
        end else begin
            show_seg = ssnd_pkg::SEG_BLANK;
        end
        blink_on = r_blink[r_scan] && (r_phase < ssnd_pkg::BLINK_ON_END);
        // phase mod 500 above 300
        ovf_on = r_ovf && ((r_phase > ssnd_pkg::OVF_ON_START_2) ||
                 ((r_phase > ssnd_pkg::OVF_ON_START) && (r_phase < ssnd_pkg::OVF_HALF)));
        if (blink_on || ovf_on) begin
            show_seg = show_seg | ssnd_pkg::SEG_DOT;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_digits_used = r_digits_used;
        n_blink       = r_blink;
        n_dwell       = r_dwell;
        n_pat         = r_pat;
        n_phase       = r_phase;
        n_cnt         = r_cnt;
        n_scan        = r_scan;
        n_ovf         = r_ovf;
        n_mag         = r_mag;
        n_neg         = r_neg;
        n_j           = r_j;
        n_out_valid   = r_out_valid;
        n_out_seg     = r_out_seg;
        n_out_dig     = r_out_dig;
        n_out_ovf     = r_out_ovf;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                ssnd_pkg::CFG_DIGITS_USED: n_digits_used = i_cfg_data[2:0];
                ssnd_pkg::CFG_BLINK_MASK:  n_blink       = i_cfg_data[3:0];
                ssnd_pkg::CFG_DWELL_TICKS: n_dwell       = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_EMIT;
                    case (ssnd_pkg::t_cmd'(i_in.command))
                        ssnd_pkg::CMD_WRITE: begin
                            n_neg   = in_raw[15];
                            n_mag   = in_raw[15] ? (16'd0 - in_raw) : in_raw;
                            n_j     = NW'(i_in.position);
                            n_ovf   = 1'b0;
                            n_state = ST_CONV;
                        end
                        ssnd_pkg::CMD_CLEAR: begin
                            for (int i = 0; i < MAX_DIGITS; i++) begin
                                if (i < int'(fitted)) begin
                                    n_pat[i] = ssnd_pkg::SEG_BLANK;
                                end
                            end
                        end
                        ssnd_pkg::CMD_TICK: begin
                            n_phase = (r_phase == ssnd_pkg::PHASE_LAST) ?
                                      '0 : r_phase + 1'b1;
                            if (cnt_inc >= dwell_eff) begin
                                n_cnt = 8'd0;
                                if (NW'(scan_inc) >= fitted) begin
                                    n_scan = 2'd0;
                                end else begin
                                    n_scan = scan_inc[1:0];
                                end
                            end else begin
                                n_cnt = cnt_inc;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CONV: begin
                if (r_j < fitted) begin
                    n_pat[AW'(r_j)] = ssnd_pkg::seg_of(rem);
                    n_j = r_j + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                n_mag = quot;
                if (quot == 16'd0) begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (r_j < fitted) begin
                    n_pat[AW'(r_j)] = ssnd_pkg::SEG_MINUS;
                end else begin
                    n_ovf = 1'b1;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_seg   = show_seg;
                    n_out_dig   = r_scan;
                    n_out_ovf   = r_ovf;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_digits_used <= ssnd_pkg::DIGITS_USED_RST;
            r_blink       <= ssnd_pkg::BLINK_MASK_RST;
            r_dwell       <= ssnd_pkg::DWELL_TICKS_RST;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_pat[i] <= ssnd_pkg::SEG_BLANK;
            end
            r_phase       <= '0;
            r_cnt         <= 8'd0;
            r_scan        <= 2'd0;
            r_ovf         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_digits_used <= n_digits_used;
            r_blink       <= n_blink;
            r_dwell       <= n_dwell;
            r_pat         <= n_pat;
            r_phase       <= n_phase;
            r_cnt         <= n_cnt;
            r_scan        <= n_scan;
            r_ovf         <= n_ovf;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_j       <= n_j;
        r_out_seg <= n_out_seg;
        r_out_dig <= n_out_dig;
        r_out_ovf <= n_out_ovf;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.segments = r_out_seg;
    assign o_out.digit    = r_out_dig;
    assign o_out.overflow = r_out_ovf;

endmodule

`default_nettype wire

>>> src/ssnd_checker.sv
// Port-level assertions for the seven-segment number display, with the bind
// that attaches them to the top level. Depends on ssnd_pkg.
`default_nettype none

module ssnd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [ssnd_pkg::SEG_W-1:0] i_out_segments,
    input logic [ssnd_pkg::DIG_W-1:0] i_out_digit,
    input logic                       i_out_overflow
);

    // a pending result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_segments) && $stable(i_out_digit) && $stable(i_out_overflow))
        else $error("stalled result changed");

    // one item at a time: busy right after each accepted item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while previous item in progress");

    // a new result is only loaded while the sequencer is busy
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without an item in progress");

endmodule

bind seven_segment_number_display ssnd_checker u_ssnd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_segments (o_out.segments),
    .i_out_digit    (o_out.digit),
    .i_out_overflow (o_out.overflow)
);

`default_nettype wire
